// ----- rtl/ngh_pkg.sv -----
package ngh_pkg;

  localparam int NGH_SAMPLE_WIDTH   = 16;
  localparam int NGH_COEF_FRAC_BITS = 16;

  localparam int LEVEL_W    = 31;
  localparam int COEFF_W    = 16;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int PC_W       = 4;

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0]  GAIN_HALF = 17'h08000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 31'h7FFFFFFF;

  localparam logic [LEVEL_W-1:0] OPEN_THR_RESET  = 31'd21475;
  localparam logic [LEVEL_W-1:0] CLOSE_THR_RESET = 31'd10763;
  localparam logic [COEFF_W-1:0] ENV_ATK_RESET   = 16'd65263;
  localparam logic [COEFF_W-1:0] ENV_REL_RESET   = 16'd65509;
  localparam logic [COEFF_W-1:0] GAIN_ATK_RESET  = 16'd65082;
  localparam logic [COEFF_W-1:0] GAIN_REL_RESET  = 16'd65527;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_THR  = 3'd0,
    REG_CLOSE_THR = 3'd1,
    REG_ENV_ATK   = 3'd2,
    REG_ENV_REL   = 3'd3,
    REG_GAIN_ATK  = 3'd4,
    REG_GAIN_REL  = 3'd5
  } ngh_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_ENV,
    MUL_GAIN,
    MUL_OUT
  } ngh_mul_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_SQ,
    WB_ENV,
    WB_TGT,
    WB_GAIN,
    WB_OUT
  } ngh_wb_t;

  typedef enum logic [1:0] {
    GO_NEXT,
    GO_IN,
    GO_OUT
  } ngh_cond_t;

  typedef struct packed {
    ngh_mul_t        mul;
    ngh_wb_t         wb;
    ngh_cond_t       cond;
    logic [PC_W-1:0] next_pc;
  } ngh_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ngh_status_t;

  // One control word per step. A step with a wait condition holds until it is met.
  function automatic ngh_ctl_t ucode(input logic [PC_W-1:0] pc);
    ngh_ctl_t w;
    case (pc)
      4'd0:    w = '{MUL_NONE, WB_NONE, GO_IN,   4'd1};
      4'd1:    w = '{MUL_SQ,   WB_NONE, GO_NEXT, 4'd2};
      4'd2:    w = '{MUL_NONE, WB_SQ,   GO_NEXT, 4'd3};
      4'd3:    w = '{MUL_ENV,  WB_NONE, GO_NEXT, 4'd4};
      4'd4:    w = '{MUL_NONE, WB_ENV,  GO_NEXT, 4'd5};
      4'd5:    w = '{MUL_NONE, WB_TGT,  GO_NEXT, 4'd6};
      4'd6:    w = '{MUL_GAIN, WB_NONE, GO_NEXT, 4'd7};
      4'd7:    w = '{MUL_NONE, WB_GAIN, GO_NEXT, 4'd8};
      4'd8:    w = '{MUL_OUT,  WB_NONE, GO_NEXT, 4'd9};
      4'd9:    w = '{MUL_NONE, WB_OUT,  GO_OUT,  4'd0};
      default: w = '{MUL_NONE, WB_NONE, GO_NEXT, 4'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/ngh_seq.sv -----
module ngh_seq
  import ngh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ngh_status_t status,
  output ngh_ctl_t    ctl
);

  logic [PC_W-1:0] pc;
  logic            advance;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.cond)
      GO_NEXT: advance = 1'b1;
      GO_IN:   advance = status.in_valid;
      GO_OUT:  advance = status.out_free;
      default: advance = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (advance) begin
      pc <= ctl.next_pc;
    end
  end

endmodule

// ----- rtl/noise_gate_with_hysteresis_core.sv -----
// Noise gate with hysteresis and voice-activity flag, one audio sample per transaction.
// Input channel (in_valid/in_ready) carries sample_in and frame_end. Output channel
// (out_valid/out_ready) returns one result per input transaction: the gain-scaled
// sample, voice_active, level_valid and, on frame end, the frame's peak squared envelope.
// A microcoded sequencer runs ten steps per sample over one shared multiplier. The result
// is loaded into the output register at the last step, and the block takes no new sample
// until the sequencer is back at its first step.
// in_ready is high only while the sequencer waits at its first step.
// The result sits in an output register; the block accepts and processes the next
// sample while it waits, and holds at its last step only if that register is still
// full when the next result is ready. A stalled receiver thus leaves at most two items
// in the block, one in the output register and one at the last step, with in_ready low.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered; they are to be
// made only while the block is idle, and the block itself does not enforce this. Reset
// is synchronous: it loads the register defaults, clears the envelope, closes the gate,
// clears the frame peak and empties the output register.
module noise_gate_with_hysteresis_core
  import ngh_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = NGH_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = NGH_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           frame_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           voice_active,
  output logic                           level_valid,
  output logic [LEVEL_W-1:0]             peak_level_sq,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int F   = COEF_FRAC_BITS;
  localparam int AW  = (SW > F + 1) ? SW : F + 1;
  localparam int BW  = 32;
  localparam int PW  = AW + 1 + BW;
  localparam int CW  = (COEFF_W > F + 1) ? COEFF_W : F + 1;
  localparam int SCW = 2 * SW + 16;
  localparam int SQ_LSH = (33 - 2 * SW > 0) ? 33 - 2 * SW : 0;
  localparam int SQ_RSH = (2 * SW - 33 > 0) ? 2 * SW - 33 : 0;
  localparam logic [CW-1:0] COEF_ONE = CW'(1) << F;

  logic [LEVEL_W-1:0] open_thr;
  logic [LEVEL_W-1:0] close_thr;
  logic [COEFF_W-1:0] env_atk;
  logic [COEFF_W-1:0] env_rel;
  logic [COEFF_W-1:0] gain_atk;
  logic [COEFF_W-1:0] gain_rel;

  logic [SW-1:0]      mag;
  logic               neg;
  logic               fend;
  logic [LEVEL_W-1:0] sq;
  logic [LEVEL_W-1:0] env;
  logic [GAIN_W-1:0]  gate_gain;
  logic [LEVEL_W-1:0] peak;
  logic               tgt_one;
  logic signed [PW-1:0] prod;

  ngh_ctl_t    ctl;
  ngh_status_t status;

  logic               in_fire;
  logic               out_free;
  logic [SW-1:0]      mag_next;
  logic [COEFF_W-1:0] env_sel;
  logic [COEFF_W-1:0] gain_sel;
  logic [CW-1:0]      env_c;
  logic [CW-1:0]      gain_c;
  logic [CW-1:0]      env_om;
  logic [CW-1:0]      gain_om;
  logic [AW-1:0]      mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [31:0] env_diff;
  logic signed [17:0] gain_diff;
  logic [GAIN_W-1:0]  gain_tgt;
  logic signed [PW-1:0] prod_shr;
  logic [63:0]        sq_wide;
  logic signed [32:0] env_sum;
  logic signed [18:0] gain_sum;
  logic [LEVEL_W-1:0] thr;
  logic [SW+16:0]     scale_p;
  logic [SCW-1:0]     scaled;
  logic [SW-1:0]      mag_out;

  assign in_ready = (ctl.cond == GO_IN);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign status   = '{in_valid: in_valid, out_free: out_free};

  ngh_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  assign mag_next = sample_in[SW-1] ? (~sample_in + 1'b1) : sample_in;

  assign env_sel  = (sq > env) ? env_atk : env_rel;
  assign gain_tgt = tgt_one ? GAIN_ONE : '0;
  assign gain_sel = (tgt_one && (gate_gain != GAIN_ONE)) ? gain_atk : gain_rel;
  assign env_c    = (CW'(env_sel) > COEF_ONE) ? COEF_ONE : CW'(env_sel);
  assign gain_c   = (CW'(gain_sel) > COEF_ONE) ? COEF_ONE : CW'(gain_sel);
  assign env_om   = COEF_ONE - env_c;
  assign gain_om  = COEF_ONE - gain_c;
  assign env_diff  = $signed({1'b0, sq}) - $signed({1'b0, env});
  assign gain_diff = $signed({1'b0, gain_tgt}) - $signed({1'b0, gate_gain});

  always_comb begin
    case (ctl.mul)
      MUL_SQ: begin
        mul_a = AW'(mag);
        mul_b = $signed(BW'(mag));
      end
      MUL_ENV: begin
        mul_a = AW'(env_om);
        mul_b = BW'(env_diff);
      end
      MUL_GAIN: begin
        mul_a = AW'(gain_om);
        mul_b = BW'(gain_diff);
      end
      MUL_OUT: begin
        mul_a = AW'(mag);
        mul_b = $signed(BW'(gate_gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_shr = prod >>> F;
  assign sq_wide  = (64'(prod[2*SW-1:0]) << SQ_LSH) >> SQ_RSH;
  assign env_sum  = $signed({2'b00, env}) + $signed(prod_shr[32:0]);
  assign gain_sum = $signed({2'b00, gate_gain}) + $signed(prod_shr[18:0]);
  assign thr      = (gate_gain > GAIN_HALF) ? close_thr : open_thr;
  assign scale_p  = prod[SW+16:0];
  assign scaled   = (SCW'(scale_p) << (SW - 1)) - SCW'(scale_p);
  assign mag_out  = scaled[SW+15 +: SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      open_thr  <= OPEN_THR_RESET;
      close_thr <= CLOSE_THR_RESET;
      env_atk   <= ENV_ATK_RESET;
      env_rel   <= ENV_REL_RESET;
      gain_atk  <= GAIN_ATK_RESET;
      gain_rel  <= GAIN_REL_RESET;
    end else if (cfg_write) begin
      case (ngh_reg_t'(cfg_index))
        REG_OPEN_THR:  open_thr  <= cfg_data[LEVEL_W-1:0];
        REG_CLOSE_THR: close_thr <= cfg_data[LEVEL_W-1:0];
        REG_ENV_ATK:   env_atk   <= cfg_data[COEFF_W-1:0];
        REG_ENV_REL:   env_rel   <= cfg_data[COEFF_W-1:0];
        REG_GAIN_ATK:  gain_atk  <= cfg_data[COEFF_W-1:0];
        REG_GAIN_REL:  gain_rel  <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag  <= mag_next;
      neg  <= sample_in[SW-1];
      fend <= frame_end;
    end
    if (ctl.mul != MUL_NONE) begin
      prod <= $signed({1'b0, mul_a}) * mul_b;
    end
    if (ctl.wb == WB_SQ) begin
      sq <= (sq_wide > 64'(LEVEL_MAX)) ? LEVEL_MAX : sq_wide[LEVEL_W-1:0];
    end
    if (ctl.wb == WB_TGT) begin
      tgt_one <= (env >= thr);
    end
    if (ctl.wb == WB_OUT && out_free) begin
      sample_out    <= neg ? (~mag_out + 1'b1) : mag_out;
      voice_active  <= (gate_gain > GAIN_HALF);
      level_valid   <= fend;
      peak_level_sq <= fend ? peak : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env       <= '0;
      gate_gain <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.wb == WB_ENV) begin
        env <= env_sum[LEVEL_W-1:0];
      end
      if (ctl.wb == WB_GAIN) begin
        gate_gain <= (gain_sum > $signed({2'b00, GAIN_ONE})) ? GAIN_ONE
                                                             : gain_sum[GAIN_W-1:0];
        if (env > peak) begin
          peak <= env;
        end
      end
      if (ctl.wb == WB_OUT && out_free) begin
        out_valid <= 1'b1;
        if (fend) begin
          peak <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an item is still being processed");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    gate_gain <= GAIN_ONE)
    else $error("gate gain above unity");

  a_peak_only_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !level_valid) |-> (peak_level_sq == '0))
    else $error("peak level reported outside frame end");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (ctl.wb == WB_OUT && out_free) |=> out_valid)
    else $error("result step did not fill the output register");
`endif

endmodule
